@@ sv/lsd_pkg.sv @@
// package for the lsd radix sorter: sizes, entry and memory request types,
// controller states and the radix clamp; no dependencies
`default_nettype none
package lsd_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 16;
	localparam int MAX_RADIX  = 16;

	localparam int CFG_W   = 5;
	localparam int ADDR_W  = $clog2(MAX_ITEMS);
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int RADIX_W = $clog2(MAX_RADIX + 1);
	localparam int DIG_W   = $clog2(MAX_RADIX);
	localparam int DIVR_W  = VALUE_BITS + RADIX_W;

	localparam logic [CFG_W-1:0] RADIX_RESET = CFG_W'(10);

	// one stored entry: the value and what is left of it after the passes so far
	typedef struct packed {
		logic [VALUE_BITS-1:0] quot;
		logic [VALUE_BITS-1:0] val;
	} lsd_entry_t;

	// access to the three memories for one cycle
	typedef struct packed {
		logic              item_we;
		logic [ADDR_W-1:0] item_addr;
		lsd_entry_t        item_wdata;
		logic              dig_we;
		logic [DIG_W-1:0]  dig_wdata;
		logic              gath_we;
		logic [ADDR_W-1:0] gath_addr;
		lsd_entry_t        gath_wdata;
	} lsd_mem_req_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_CNT_RD,
		ST_CNT_DIV,
		ST_CNT_WAIT,
		ST_PREFIX,
		ST_DIST_RD,
		ST_DIST_WR,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_OUT_RD,
		ST_OUT_SHOW
	} lsd_state_t;

	// clamp the register to the supported bases
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [CFG_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < CFG_W'(2)) begin
			res = RADIX_W'(2);
		end else if (r > CFG_W'(MAX_RADIX)) begin
			res = RADIX_W'(MAX_RADIX);
		end else begin
			res = RADIX_W'(r);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

@@ sv/lsd_if.sv @@
// stream interfaces of the lsd radix sorter: input items and sorted results
// depends on lsd_pkg
`default_nettype none
interface lsd_in_if;
	logic                          valid;
	logic                          ready;
	logic [lsd_pkg::VALUE_BITS-1:0] value;
	logic                          last_in;
	modport source (output valid, output value, output last_in, input ready);
	modport sink (input valid, input value, input last_in, output ready);
endinterface

interface lsd_out_if;
	logic                          valid;
	logic                          ready;
	logic [lsd_pkg::VALUE_BITS-1:0] sorted_value;
	logic                          last_out;
	logic                          dropped;
	modport source (output valid, output sorted_value, output last_out, output dropped,
		input ready);
	modport sink (input valid, input sorted_value, input last_out, input dropped,
		output ready);
endinterface
`default_nettype wire

@@ sv/lsd_radix_sorter_top.sv @@
// channel   | dir | payload                              | item accepted when
// items     | in  | value, last_in                       | valid && ready
// results   | out | sorted_value, last_out, dropped      | valid && ready
// cfg       | in  | radix (cfg_wdata)                    | cfg_we
//
// loading takes one item per cycle; an item with last_in starts the sort
// each pass costs per item a read, a divide and a write, then a prefix sum over
// the radix digit counts, then per item a read and a write to distribute and again to copy
// passes run while radix^pass <= largest value; each result is read, then shown
// items are refused while sorting or emitting; a stalled result just holds
// arst_n clears control state; memory contents are not reset
// depends on lsd_pkg, lsd_if, lsd_div, lsd_store
`default_nettype none
module lsd_radix_sorter_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [lsd_pkg::CFG_W-1:0] cfg_wdata,
	lsd_in_if.sink                         items,
	lsd_out_if.source                      results
);
	import lsd_pkg::*;

	lsd_state_t            state_q, state_d;
	logic [CFG_W-1:0]      radix_q;
	logic [CNT_W-1:0]      count_q;
	logic [VALUE_BITS-1:0] largest_q;
	logic                  ovf_q;
	logic [CNT_W-1:0]      idx_q;
	logic [DIG_W:0]        pidx_q;
	logic [CNT_W-1:0]      run_q;
	logic [DIVR_W-1:0]     divisor_q;
	logic [CNT_W-1:0]      counts_q [MAX_RADIX];

	logic [RADIX_W-1:0]    r_eff;
	lsd_mem_req_t          req;
	lsd_entry_t            item_rdata, gath_rdata;
	logic [DIG_W-1:0]      dig_rdata;
	logic                  div_start, div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [DIG_W-1:0]      div_rem;
	logic                  in_acc, out_acc, room, idx_end, pidx_end, is_last;
	logic                  pass_go;
	lsd_entry_t            load_entry;

	assign r_eff    = eff_radix(radix_q);
	assign in_acc   = items.valid && items.ready;
	assign out_acc  = results.valid && results.ready;
	assign room     = count_q < CNT_W'(MAX_ITEMS);
	assign idx_end  = (idx_q + CNT_W'(1)) == count_q;
	assign pidx_end = (pidx_q + (DIG_W+1)'(1)) == (DIG_W+1)'(r_eff);
	assign pass_go  = divisor_q <= DIVR_W'(largest_q);
	assign is_last  = idx_end;
	assign load_entry.quot = items.value;
	assign load_entry.val  = items.value;

	lsd_store u_store (
		.clk        (clk),
		.req        (req),
		.item_rdata (item_rdata),
		.dig_rdata  (dig_rdata),
		.gath_rdata (gath_rdata)
	);

	lsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (item_rdata.quot),
		.divisor  (r_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (in_acc && items.last_in) state_d = ST_CHECK;
			ST_CHECK:    state_d = pass_go ? ST_CNT_RD : ST_OUT_RD;
			ST_CNT_RD:   state_d = ST_CNT_DIV;
			ST_CNT_DIV:  state_d = ST_CNT_WAIT;
			ST_CNT_WAIT: if (div_done) state_d = idx_end ? ST_PREFIX : ST_CNT_RD;
			ST_PREFIX:   if (pidx_end) state_d = ST_DIST_RD;
			ST_DIST_RD:  state_d = ST_DIST_WR;
			ST_DIST_WR:  state_d = idx_end ? ST_COPY_RD : ST_DIST_RD;
			ST_COPY_RD:  state_d = ST_COPY_WR;
			ST_COPY_WR:  state_d = idx_end ? ST_CHECK : ST_COPY_RD;
			ST_OUT_RD:   state_d = ST_OUT_SHOW;
			ST_OUT_SHOW: if (out_acc) state_d = is_last ? ST_LOAD : ST_OUT_RD;
			default:     state_d = ST_LOAD;
		endcase
	end

	// outputs and memory access
	always_comb begin
		items.ready    = 1'b0;
		results.valid  = 1'b0;
		div_start      = 1'b0;
		req            = '0;
		req.item_addr  = idx_q[ADDR_W-1:0];
		req.gath_addr  = idx_q[ADDR_W-1:0];
		case (state_q)
			ST_LOAD: begin
				items.ready    = 1'b1;
				req.item_addr  = count_q[ADDR_W-1:0];
				req.item_we    = in_acc && room;
				req.item_wdata = load_entry;
			end
			ST_CNT_DIV: div_start = 1'b1;
			ST_CNT_WAIT: begin
				req.item_we         = div_done;
				req.item_wdata.quot = div_quot;
				req.item_wdata.val  = item_rdata.val;
				req.dig_we          = div_done;
				req.dig_wdata       = div_rem;
			end
			ST_DIST_WR: begin
				req.gath_we    = 1'b1;
				req.gath_addr  = counts_q[dig_rdata][ADDR_W-1:0];
				req.gath_wdata = item_rdata;
			end
			ST_COPY_WR: begin
				req.item_we    = 1'b1;
				req.item_wdata = gath_rdata;
			end
			ST_OUT_SHOW: results.valid = 1'b1;
			default: ;
		endcase
	end

	assign results.sorted_value = item_rdata.val;
	assign results.last_out     = is_last;
	assign results.dropped      = ovf_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			radix_q   <= RADIX_RESET;
			count_q   <= '0;
			largest_q <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			pidx_q    <= '0;
			run_q     <= '0;
			divisor_q <= DIVR_W'(1);
			for (int i = 0; i < MAX_RADIX; i++) counts_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) radix_q <= cfg_wdata;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
							if (items.value > largest_q) largest_q <= items.value;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_CHECK: begin
					idx_q  <= '0;
					pidx_q <= '0;
					run_q  <= '0;
					for (int i = 0; i < MAX_RADIX; i++) counts_q[i] <= '0;
				end
				ST_CNT_WAIT: begin
					if (div_done) begin
						counts_q[div_rem] <= counts_q[div_rem] + CNT_W'(1);
						idx_q <= idx_end ? '0 : idx_q + CNT_W'(1);
					end
				end
				ST_PREFIX: begin
					counts_q[pidx_q[DIG_W-1:0]] <= run_q;
					run_q  <= run_q + counts_q[pidx_q[DIG_W-1:0]];
					pidx_q <= pidx_q + (DIG_W+1)'(1);
				end
				ST_DIST_WR: begin
					counts_q[dig_rdata] <= counts_q[dig_rdata] + CNT_W'(1);
					idx_q <= idx_end ? '0 : idx_q + CNT_W'(1);
				end
				ST_COPY_WR: begin
					idx_q <= idx_end ? '0 : idx_q + CNT_W'(1);
					if (idx_end) divisor_q <= DIVR_W'(divisor_q * r_eff);
				end
				ST_OUT_SHOW: begin
					if (out_acc) begin
						idx_q <= is_last ? '0 : idx_q + CNT_W'(1);
						if (is_last) begin
							count_q   <= '0;
							largest_q <= '0;
							ovf_q     <= 1'b0;
							divisor_q <= DIVR_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS)) else $error("item count above capacity");
	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> count_q != '0 && idx_q < count_q)
		else $error("result shown from an empty set");
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && results.last_out |=> state_q == ST_LOAD && count_q == '0 && !ovf_q)
		else $error("set not cleared after final result");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LOAD |-> !req.item_we || state_q == ST_CNT_WAIT || state_q == ST_COPY_WR)
		else $error("item store written outside its phases");
endmodule
`default_nettype wire

@@ sv/lsd_div.sv @@
// iterative restoring divider: value by radix, one quotient bit per cycle
// depends on lsd_pkg
`default_nettype none
module lsd_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [lsd_pkg::VALUE_BITS-1:0] dividend,
	input  wire logic [lsd_pkg::RADIX_W-1:0]    divisor,
	output logic                                done,
	output logic [lsd_pkg::VALUE_BITS-1:0]      quot,
	output logic [lsd_pkg::DIG_W-1:0]           rem
);
	import lsd_pkg::*;

	localparam int STEP_W = $clog2(VALUE_BITS + 1);

	logic                   busy_q;
	logic [STEP_W-1:0]      step_q;
	logic [VALUE_BITS-1:0]  quot_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     dvs_q;
	logic                   done_q;
	logic [RADIX_W:0]       rem_sh;
	logic                   fits;

	// shift in the next dividend bit and try a subtract
	assign rem_sh = {rem_q, quot_q[VALUE_BITS-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_BITS);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[VALUE_BITS-2:0], fits};
			rem_q  <= fits ? RADIX_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[RADIX_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q[DIG_W-1:0];

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not go busy");
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dvs_q) else $error("remainder not below radix");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
endmodule
`default_nettype wire

@@ sv/lsd_store.sv @@
// item, digit and gather memories, one synchronous port each, registered reads
// depends on lsd_pkg
`default_nettype none
module lsd_store (
	input  wire logic                  clk,
	input  wire lsd_pkg::lsd_mem_req_t req,
	output lsd_pkg::lsd_entry_t        item_rdata,
	output logic [lsd_pkg::DIG_W-1:0]  dig_rdata,
	output lsd_pkg::lsd_entry_t        gath_rdata
);
	import lsd_pkg::*;

	lsd_entry_t       item_mem [MAX_ITEMS];
	logic [DIG_W-1:0] dig_mem  [MAX_ITEMS];
	lsd_entry_t       gath_mem [MAX_ITEMS];

	// item store with its digit side memory at the same address
	always_ff @(posedge clk) begin
		if (req.item_we) begin
			item_mem[req.item_addr] <= req.item_wdata;
		end
		if (req.dig_we) begin
			dig_mem[req.item_addr] <= req.dig_wdata;
		end
		item_rdata <= item_mem[req.item_addr];
		dig_rdata  <= dig_mem[req.item_addr];
	end

	// gather store
	always_ff @(posedge clk) begin
		if (req.gath_we) begin
			gath_mem[req.gath_addr] <= req.gath_wdata;
		end
		gath_rdata <= gath_mem[req.gath_addr];
	end
endmodule
`default_nettype wire

@@ tb/sv/lsd_radix_sorter_top_test.sv @@
// testbench for lsd_radix_sorter_top: drives value sets, predicts the sorted output
// depends on lsd_pkg, lsd_if and the sorter top level
`timescale 1ns / 100ps
`default_nettype none
module lsd_radix_sorter_top_test;
	import lsd_pkg::*;

	typedef struct packed {
		logic [VALUE_BITS-1:0] sorted_value;
		logic                  last_out;
		logic                  dropped;
	} sorted_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	int errors = 0;

	lsd_in_if items ();
	lsd_out_if results ();

	lsd_radix_sorter_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.items(items.sink), .results(results.source)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [CFG_W-1:0] radix_reg = RADIX_RESET;
	logic [VALUE_BITS-1:0] set_vals[$];
	bit set_overflow = 0;
	sorted_t sorted_q[$];

	initial begin
		items.valid = 1'b0;
		items.value = '0;
		items.last_in = 1'b0;
		results.ready = 1'b0;
	end

	// predict results of one accepted item
	task automatic predict_item(input logic [VALUE_BITS-1:0] v, input bit last);
		int r, n;
		longint divisor, largest;
		logic [VALUE_BITS-1:0] buckets[16][$];
		if (set_vals.size() < MAX_ITEMS) set_vals.push_back(v);
		else set_overflow = 1;
		if (!last) return;
		r = (radix_reg < 2) ? 2 : (radix_reg > MAX_RADIX) ? MAX_RADIX : radix_reg;
		largest = 0;
		foreach (set_vals[i]) if (set_vals[i] > largest) largest = set_vals[i];
		divisor = 1;
		while (divisor <= largest) begin
			for (int d = 0; d < 16; d++) buckets[d].delete();
			foreach (set_vals[i]) buckets[(set_vals[i] / divisor) % r].push_back(set_vals[i]);
			set_vals.delete();
			for (int d = 0; d < r; d++) foreach (buckets[d][j]) set_vals.push_back(buckets[d][j]);
			divisor *= r;
		end
		n = set_vals.size();
		for (int i = 0; i < n; i++)
			sorted_q.push_back('{set_vals[i], (i == n - 1), set_overflow});
		set_vals.delete();
		set_overflow = 0;
	endtask

	// send one item after a random gap; valid stays high until the next gap
	task automatic send_item(input logic [VALUE_BITS-1:0] v, input bit last);
		int gap;
		gap = $urandom_range(0, 8);
		if (gap != 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.value <= v;
		items.last_in <= last;
		@(posedge clk iff items.ready);
		predict_item(v, last);
	endtask

	// drop valid after the last item sent
	task automatic stop_items();
		items.valid <= 1'b0;
		@(posedge clk);
	endtask

	// idle wait then register write
	task automatic write_radix(input logic [CFG_W-1:0] r);
		stop_items();
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_reg = r;
	endtask

	task automatic send_set(input int n, input int vmax);
		for (int i = 0; i < n; i++)
			send_item($urandom_range(0, vmax), i == n - 1);
	endtask

	task automatic test_directed();
		send_item(16'h0000, 1'b1);
		send_item(16'hffff, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'h8001, 1'b0);
		send_item(16'h7ffe, 1'b0);
		send_item(16'h0005, 1'b0);
		send_item(16'h0005, 1'b1);
		write_radix(5'd0);
		send_set(4, 65535);
		write_radix(5'd31);
		send_set(4, 65535);
		write_radix(5'd1);
		send_set(3, 7);
	endtask

	// overflow: more than the store holds, last item itself dropped
	task automatic test_overflow();
		write_radix(5'd16);
		send_set(MAX_ITEMS + 3, 65535);
	endtask

	task automatic test_random();
		int sent = 0, n;
		while (sent < 285) begin
			if ($urandom_range(0, 3) == 0) write_radix($urandom_range(0, 31));
			n = $urandom_range(1, 12);
			send_set(n, ($urandom_range(0, 2) == 0) ? 15 : 65535);
			sent += n;
		end
	endtask

	// result checker with random stall
	initial begin
		sorted_t got, want;
		int gap;
		forever begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				results.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results.ready <= 1'b1;
			@(posedge clk iff results.valid);
			got = '{results.sorted_value, results.last_out, results.dropped};
			if (sorted_q.size() == 0) begin
				$error("result with nothing expected: value %0h", got.sorted_value);
				errors++;
			end else begin
				want = sorted_q.pop_front();
				if (got.sorted_value !== want.sorted_value) begin
					$error("sorted_value expected %0h actual %0h", want.sorted_value,
						got.sorted_value);
					errors++;
				end
				if (got.last_out !== want.last_out) begin
					$error("last_out expected %0b actual %0b", want.last_out, got.last_out);
					errors++;
				end
				if (got.dropped !== want.dropped) begin
					$error("dropped expected %0b actual %0b", want.dropped, got.dropped);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random();
		stop_items();
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && sorted_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
sv/lsd_pkg.sv
sv/lsd_if.sv
sv/lsd_div.sv
sv/lsd_store.sv
sv/lsd_radix_sorter_top.sv
tb/sv/lsd_radix_sorter_top_test.sv
